### src/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue.
package tcpq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 32;
    localparam int unsigned DEF_MAX_IDENT   = 1023;
    localparam int          ID_W            = 10;
    localparam int          COUNT_W         = 6;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DEPART = 2'd2,
        OP_TEST   = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic dn_init;
        logic dn_step;
        logic up_init;
        logic up_step;
        logic insert;
        logic drop;
        logic set_result;
        logic res_ok;
        logic res_present;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic id_ok;
        logic class_ok;
        logic full;
        logic dn_done;
        logic up_done;
        logic out_busy;
        op_t  op;
    } dp_stat_t;

endpackage

### src/tcpq_req_if.sv
// Request channel interface of the two-class priority queue.
interface tcpq_req_if;
    logic                      valid;
    logic                      ready;
    tcpq_pkg::op_t             opcode;
    logic [tcpq_pkg::ID_W-1:0] item_id;
    logic                      item_class;
    logic                      urgent;

    modport source (output valid, output opcode, output item_id, output item_class,
                    output urgent, input ready);
    modport sink (input valid, input opcode, input item_id, input item_class,
                  input urgent, output ready);
endinterface

### src/tcpq_rsp_if.sv
// Result channel interface of the two-class priority queue.
interface tcpq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic                         present;
    logic [tcpq_pkg::COUNT_W-1:0] entry_count;
    logic [tcpq_pkg::ID_W-1:0]    departed_id;

    modport source (output valid, output ok, output present, output entry_count,
                    output departed_id, input ready);
    modport sink (input valid, input ok, input present, input entry_count,
                  input departed_id, output ready);
endinterface

### src/tcpq_datapath.sv
// Datapath of the two-class priority queue: slot memory, counters and result register.
module tcpq_datapath #(
    parameter int unsigned QUEUE_DEPTH = tcpq_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned MAX_IDENT   = tcpq_pkg::DEF_MAX_IDENT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tcpq_pkg::dp_cmd_t         cmd,
    output tcpq_pkg::dp_stat_t        stat,
    input  tcpq_pkg::op_t             in_opcode,
    input  logic [tcpq_pkg::ID_W-1:0] in_item_id,
    input  logic                      in_item_class,
    input  logic                      in_urgent,
    input  logic                      cfg_we,
    input  logic                      cfg_wdata,
    tcpq_rsp_if.source                rsp
);
    import tcpq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            urg;
    } slot_t;

    slot_t mem [QUEUE_DEPTH];

    op_t              op_reg;
    logic [ID_W-1:0]  id_reg;
    logic             cls_reg;
    logic             urg_reg;
    logic             qclass_reg;
    logic [OW-1:0]    occ_reg;
    logic [OW-1:0]    ucnt_reg;
    logic [OW-1:0]    rd_ptr_reg;
    logic [OW-1:0]    pos_reg;
    logic             rvalid_reg;
    logic [AW-1:0]    raddr_q_reg;
    slot_t            rdata_reg;
    logic             found_reg;
    logic [ID_W-1:0]  hit_id_reg;
    logic             hit_urg_reg;
    logic             out_valid_reg;
    logic             ok_reg;
    logic             present_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ID_W-1:0]  departed_reg;

    logic             scan_issue;
    logic             dn_issue;
    logic             up_issue;
    logic             rd_en;
    logic [OW-1:0]    up_src;
    logic [AW-1:0]    rd_addr;
    logic             match;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    slot_t            wr_data;
    logic [31:0]      occ_wide;
    logic [ID_W-1:0]  departed_next;

    assign scan_issue = cmd.scan && !found_reg && (rd_ptr_reg < occ_reg);
    assign dn_issue   = cmd.dn_step && (rd_ptr_reg < occ_reg);
    assign up_issue   = cmd.up_step && (rd_ptr_reg > pos_reg);
    assign rd_en      = scan_issue || dn_issue || up_issue;
    assign up_src     = rd_ptr_reg - OW'(1);
    assign rd_addr    = up_issue ? up_src[AW-1:0] : rd_ptr_reg[AW-1:0];

    // Depart takes whatever sits at the head; the other commands look for the id.
    assign match = rvalid_reg && cmd.scan && !found_reg &&
                   ((op_reg == OP_DEPART) ? (raddr_q_reg == '0)
                                          : (rdata_reg.id == id_reg));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = raddr_q_reg;
        wr_data = rdata_reg;
        priority if (cmd.insert)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[AW-1:0];
            wr_data = '{id: id_reg, urg: urg_reg};
        end
        else if (cmd.dn_step && rvalid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = raddr_q_reg - AW'(1);
        end
        else if (cmd.up_step && rvalid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = raddr_q_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_opcode;
            id_reg  <= in_item_id;
            cls_reg <= in_item_class;
            urg_reg <= in_urgent;
        end
        if (rd_en)
        begin
            raddr_q_reg <= rd_addr;
        end
        if (match)
        begin
            hit_id_reg  <= rdata_reg.id;
            hit_urg_reg <= rdata_reg.urg;
        end
        if (cmd.set_result)
        begin
            ok_reg       <= cmd.res_ok;
            present_reg  <= cmd.res_present;
            count_reg    <= occ_wide[COUNT_W-1:0];
            departed_reg <= departed_next;
        end
    end

    assign occ_wide      = 32'(occ_reg);
    assign departed_next = ((op_reg == OP_DEPART) && cmd.res_ok) ? hit_id_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qclass_reg    <= 1'b0;
            occ_reg       <= '0;
            ucnt_reg      <= '0;
            rd_ptr_reg    <= '0;
            pos_reg       <= '0;
            rvalid_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                qclass_reg <= cfg_wdata;
            end
            rvalid_reg <= rd_en;
            if (cmd.load)
            begin
                found_reg  <= 1'b0;
                rd_ptr_reg <= '0;
            end
            else if (cmd.dn_init)
            begin
                rd_ptr_reg <= pos_reg + OW'(1);
            end
            else if (cmd.up_init)
            begin
                rd_ptr_reg <= occ_reg;
                pos_reg    <= urg_reg ? ucnt_reg : occ_reg;
            end
            else if (scan_issue || dn_issue)
            begin
                rd_ptr_reg <= rd_ptr_reg + OW'(1);
            end
            else if (up_issue)
            begin
                rd_ptr_reg <= up_src;
            end
            if (match)
            begin
                found_reg <= 1'b1;
                pos_reg   <= OW'(raddr_q_reg);
            end
            if (cmd.insert)
            begin
                occ_reg  <= occ_reg + OW'(1);
                ucnt_reg <= ucnt_reg + OW'(urg_reg);
            end
            else if (cmd.drop)
            begin
                occ_reg  <= occ_reg - OW'(1);
                ucnt_reg <= ucnt_reg - OW'(hit_urg_reg);
            end
            if (cmd.set_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.scan_done = !rvalid_reg && (found_reg || (rd_ptr_reg >= occ_reg));
        stat.found     = found_reg;
        stat.id_ok     = (id_reg != '0) && (32'(id_reg) <= MAX_IDENT);
        stat.class_ok  = (cls_reg == qclass_reg);
        stat.full      = (occ_reg == OW'(QUEUE_DEPTH));
        stat.dn_done   = !rvalid_reg && (rd_ptr_reg >= occ_reg);
        stat.up_done   = !rvalid_reg && (rd_ptr_reg <= pos_reg);
        stat.out_busy  = out_valid_reg && !rsp.ready;
        stat.op        = op_reg;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = ok_reg;
    assign rsp.present     = present_reg;
    assign rsp.entry_count = count_reg;
    assign rsp.departed_id = departed_reg;

endmodule

### src/tcpq_ctrl.sv
// Controller state machine of the two-class priority queue.
module tcpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcpq_pkg::dp_stat_t stat,
    output tcpq_pkg::dp_cmd_t  cmd
);
    import tcpq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DN_INIT,
        ST_DN,
        ST_DROP,
        ST_UP_INIT,
        ST_UP,
        ST_INSERT,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   res_ok_reg;
    logic   res_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            res_ok_reg      <= 1'b0;
            res_present_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    res_ok_reg      <= 1'b0;
                    res_present_reg <= 1'b0;
                    if (in_valid)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (stat.scan_done)
                    begin
                        unique case (stat.op)
                            OP_ADD:
                            begin
                                if (stat.id_ok && stat.class_ok && !stat.full && !stat.found)
                                begin
                                    state_reg <= ST_UP_INIT;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            OP_REMOVE:
                            begin
                                state_reg <= (stat.id_ok && stat.found) ? ST_DN_INIT : ST_DONE;
                            end
                            OP_DEPART:
                            begin
                                state_reg <= stat.found ? ST_DN_INIT : ST_DONE;
                            end
                            OP_TEST:
                            begin
                                res_present_reg <= stat.id_ok && stat.found;
                                state_reg       <= ST_DONE;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_DN_INIT:
                begin
                    state_reg <= ST_DN;
                end
                ST_DN:
                begin
                    if (stat.dn_done)
                    begin
                        state_reg <= ST_DROP;
                    end
                end
                ST_DROP:
                begin
                    res_ok_reg <= 1'b1;
                    state_reg  <= ST_DONE;
                end
                ST_UP_INIT:
                begin
                    state_reg <= ST_UP;
                end
                ST_UP:
                begin
                    if (stat.up_done)
                    begin
                        state_reg <= ST_INSERT;
                    end
                end
                ST_INSERT:
                begin
                    res_ok_reg <= 1'b1;
                    state_reg  <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!stat.out_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd             = '0;
        cmd.load        = (state_reg == ST_IDLE) && in_valid;
        cmd.scan        = (state_reg == ST_SCAN);
        cmd.dn_init     = (state_reg == ST_DN_INIT);
        cmd.dn_step     = (state_reg == ST_DN);
        cmd.drop        = (state_reg == ST_DROP);
        cmd.up_init     = (state_reg == ST_UP_INIT);
        cmd.up_step     = (state_reg == ST_UP);
        cmd.insert      = (state_reg == ST_INSERT);
        cmd.set_result  = (state_reg == ST_DONE) && !stat.out_busy;
        cmd.res_ok      = res_ok_reg;
        cmd.res_present = res_present_reg;
    end

endmodule

### src/two_class_priority_queue.sv
// Top level of the two-class priority queue.
// The queue keeps up to QUEUE_DEPTH unique ids in one ordered slot memory: urgent
// entries form a prefix in arrival order and normal entries follow in arrival order.
// Requests are add, remove by id, depart head and test presence, and each request
// gives exactly one result with ok, present, the entry count afterwards and the id
// that departed. One request is handled at a time. A request first walks the
// occupied slots one per cycle until it finds its id, then an add or a removal
// shifts the entries behind the affected slot one per cycle through the single
// write port of the slot memory. The result sits in an output register, so the next
// request is accepted while a result still waits to be taken. The queue class
// register may be written only while the queue is idle.
module two_class_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = tcpq_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned MAX_IDENT   = tcpq_pkg::DEF_MAX_IDENT
) (
    input  logic        clk,
    input  logic        rst_n,
    tcpq_req_if.sink    req,
    tcpq_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import tcpq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    assign req.ready = in_ready;

    tcpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_IDENT   (MAX_IDENT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_opcode     (req.opcode),
        .in_item_id    (req.item_id),
        .in_item_class (req.item_class),
        .in_urgent     (req.urgent),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .rsp           (rsp)
    );

endmodule
